>>> rtl/core/tmcb_pkg.sv
// ----------------------------------------------------------------------------
// tmcb_pkg
// Shared types and constants of the text console buffer: the item and result
// payloads, operation and character codes, register indexes and the control
// and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package tmcb_pkg;

	// Fixed field widths of the payload
	localparam int CURSOR_W  = 12;
	localparam int CELL_W    = 15;

	// Operation codes
	localparam logic [2:0] MODE_CHAR      = 3'd0;
	localparam logic [2:0] MODE_SET       = 3'd1;
	localparam logic [2:0] MODE_VIEW_UP   = 3'd2;
	localparam logic [2:0] MODE_VIEW_DOWN = 3'd3;
	localparam logic [2:0] MODE_CLEAR     = 3'd4;
	localparam logic [2:0] MODE_READ      = 3'd5;

	// Character codes
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_FF    = 8'h0C;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;

	// Colors of a blank cell after reset
	localparam logic [3:0] FG_RESET = 4'h7;
	localparam logic [2:0] BG_RESET = 3'h0;

	// Configuration register indexes
	localparam logic [1:0] CFG_INK   = 2'd0;
	localparam logic [1:0] CFG_PAPER = 2'd1;
	localparam logic [1:0] CFG_IRQEN = 2'd2;

	typedef struct packed {
		logic [2:0]  mode;
		logic [7:0]  char_code;
		logic [11:0] cursor_value;
		logic [4:0]  view_row;
		logic [6:0]  view_col;
	} tmcb_req_t;

	typedef struct packed {
		logic [11:0] cursor_out;
		logic [3:0]  view_start_out;
		logic [5:0]  filled_rows_out;
		logic [7:0]  cell_char;
		logic [3:0]  cell_fg;
		logic [2:0]  cell_bg;
		logic        cell_blank;
		logic        irq;
		logic        more_above;
		logic        more_below;
	} tmcb_rsp_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic latch;
		logic exec;
		logic write;
		logic blank_init;
		logic sweep;
		logic fill_reset;
		logic div_apply;
		logic finish;
	} tmcb_cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic [2:0] mode;
		logic       shift_pend;
		logic       last_col;
		logic       last_row;
	} tmcb_sts_t;

	// Pack a cell as {paper, ink, character}
	function automatic logic [CELL_W-1:0] make_cell(input logic [7:0] ch,
			input logic [3:0] fg, input logic [2:0] bg);
		return {bg, fg, ch};
	endfunction

endpackage

>>> rtl/core/text_mode_console_buffer.sv
// ----------------------------------------------------------------------------
// text_mode_console_buffer
// Text console with a scroll-back store of VISIBLE_ROWS + HISTORY_ROWS rows of
// COLUMNS cells, written by character, cursor, view, clear and read commands.
// ----------------------------------------------------------------------------
// Usage:
//   Issue a command on item with start while busy is low; it is taken at that
//   edge. Exactly one result follows on result with result_valid high for one
//   cycle; the receiver always takes it, there is no back-pressure.
//   Registers (ink, paper, irq enable) are written over cfg_valid/cfg_ready,
//   cfg_index, cfg_data; cfg_ready is always high. Write them while idle.
//   Steps from accept to result strobe:
//     character: write the cell, then blank the new last row when it scrolls;
//     set cursor: row from a reciprocal multiply, then column and clamp;
//     view up/down and unused codes: no store access; read cell: one read;
//     clear: the whole store, one store word per cycle through the RAM port.
//   Scrolling moves a ring offset, so only the new last row is rewritten.
//   After reset the store is swept to spaces, color 7 on 0, one cell a cycle,
//   with busy high until the sweep is through; register writes are taken
//   during the sweep.
// ----------------------------------------------------------------------------
module text_mode_console_buffer import tmcb_pkg::*; #(
	parameter int COLUMNS      = 80,
	parameter int VISIBLE_ROWS = 25,
	parameter int HISTORY_ROWS = 10
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  tmcb_req_t  item,
	output logic       result_valid,
	output tmcb_rsp_t  result,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [3:0] cfg_data
);

	tmcb_cmd_t cmd;
	tmcb_sts_t sts;

	assign cfg_ready = 1'b1;

	tmcb_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.sts   (sts),
		.cmd   (cmd),
		.busy  (busy)
	);

	tmcb_dpath #(
		.COLUMNS     (COLUMNS),
		.VISIBLE_ROWS(VISIBLE_ROWS),
		.HISTORY_ROWS(HISTORY_ROWS)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.item        (item),
		.cfg_valid   (cfg_valid & cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.result_valid(result_valid),
		.result      (result)
	);

	// A result strobe lasts one cycle
	a_strobe_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !result_valid)
		else $error("result strobe held longer than one cycle");

	// An accepted transaction keeps the block busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted transaction did not raise busy");

	// The result leaves with the block back in idle
	a_strobe_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !busy)
		else $error("result strobe while busy");

	// The view never starts beyond the history rows
	a_view_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (int'(result.view_start_out) <= HISTORY_ROWS))
		else $error("view start out of range");

endmodule

>>> rtl/core/tmcb_ram.sv
// ----------------------------------------------------------------------------
// tmcb_ram
// Generic single-port RAM with one write or read per cycle and registered
// read data.
// ----------------------------------------------------------------------------
module tmcb_ram #(
	parameter int WIDTH = 15,
	parameter int DEPTH = 2800
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write on enable, register the read word every cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata_q <= mem[addr];
	end

	assign rdata = rdata_q;

endmodule

>>> rtl/core/tmcb_ctrl.sv
// ----------------------------------------------------------------------------
// tmcb_ctrl
// Controller of the text console buffer: sequences the initial store sweep,
// each operation's steps and the result strobe.
// ----------------------------------------------------------------------------
module tmcb_ctrl import tmcb_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  tmcb_sts_t sts,
	output tmcb_cmd_t cmd,
	output logic      busy
);

	localparam logic [3:0] ST_INIT   = 4'd0;
	localparam logic [3:0] ST_IDLE   = 4'd1;
	localparam logic [3:0] ST_EXEC   = 4'd2;
	localparam logic [3:0] ST_WRITE  = 4'd3;
	localparam logic [3:0] ST_BINIT  = 4'd4;
	localparam logic [3:0] ST_BLANK  = 4'd5;
	localparam logic [3:0] ST_CLEAR  = 4'd6;
	localparam logic [3:0] ST_READ   = 4'd7;
	localparam logic [3:0] ST_DAPPLY = 4'd9;
	localparam logic [3:0] ST_DONE   = 4'd10;

	logic [3:0] state_q;
	logic [3:0] state_d;

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_INIT: begin
				cmd.sweep      = 1'b1;
				cmd.fill_reset = 1'b1;
				if (sts.last_col && sts.last_row) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (start) begin
					cmd.latch = 1'b1;
					state_d   = ST_EXEC;
				end
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
				case (sts.mode)
					MODE_CHAR:  state_d = ST_WRITE;
					MODE_SET:   state_d = ST_DAPPLY;
					MODE_CLEAR: state_d = ST_CLEAR;
					MODE_READ:  state_d = ST_READ;
					default:    state_d = ST_DONE;
				endcase
			end
			ST_WRITE: begin
				cmd.write = 1'b1;
				state_d   = sts.shift_pend ? ST_BINIT : ST_DONE;
			end
			ST_BINIT: begin
				cmd.blank_init = 1'b1;
				state_d        = ST_BLANK;
			end
			ST_BLANK: begin
				cmd.sweep = 1'b1;
				if (sts.last_col) begin
					state_d = ST_DONE;
				end
			end
			ST_CLEAR: begin
				cmd.sweep = 1'b1;
				if (sts.last_col && sts.last_row) begin
					state_d = ST_DONE;
				end
			end
			ST_READ: begin
				state_d = ST_DONE;
			end
			ST_DAPPLY: begin
				cmd.div_apply = 1'b1;
				state_d       = ST_DONE;
			end
			ST_DONE: begin
				cmd.finish = 1'b1;
				state_d    = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Hold the state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != ST_IDLE);

endmodule

>>> rtl/core/tmcb_dpath.sv
// ----------------------------------------------------------------------------
// tmcb_dpath
// Datapath of the text console buffer: cursor, view and fill registers, the
// ring offset of the store, the store pointer, the cursor row and column
// split, the configuration registers and the result register.
// ----------------------------------------------------------------------------
module tmcb_dpath import tmcb_pkg::*; #(
	parameter int COLUMNS      = 80,
	parameter int VISIBLE_ROWS = 25,
	parameter int HISTORY_ROWS = 10
) (
	input  logic      clk,
	input  logic      arst_n,
	input  tmcb_cmd_t cmd,
	output tmcb_sts_t sts,
	input  tmcb_req_t item,
	input  logic      cfg_valid,
	input  logic [1:0] cfg_index,
	input  logic [3:0] cfg_data,
	output logic      result_valid,
	output tmcb_rsp_t result
);

	localparam int TOTAL = VISIBLE_ROWS + HISTORY_ROWS;
	localparam int CELLS = TOTAL * COLUMNS;
	localparam int AW    = $clog2(CELLS);
	localparam int CW    = $clog2(COLUMNS);
	localparam int PRW   = $clog2(TOTAL);
	localparam int FW    = $clog2(TOTAL + 2);
	localparam int SW    = $clog2(2 * TOTAL);
	localparam int VW    = $clog2(HISTORY_ROWS + 1);
	localparam int RS    = CURSOR_W + CW;
	localparam int RW    = CURSOR_W + 1;
	localparam int RECIP = ((1 << RS) + COLUMNS - 1) / COLUMNS;

	tmcb_req_t         req_q;
	logic [3:0]        ink_q;
	logic [2:0]        paper_q;
	logic              irqen_q;
	logic [FW-1:0]     row_q;
	logic [CW-1:0]     col_q;
	logic [VW-1:0]     vs_q;
	logic [FW-1:0]     filled_q;
	logic [PRW-1:0]    base_q;
	logic [PRW-1:0]    prow_q;
	logic [CW-1:0]     pcol_q;
	logic              shift_q;
	logic              wr_q;
	logic              pulse_q;
	logic              blank_q;
	logic [CURSOR_W-1:0] dq_q;
	logic              strobe_q;
	tmcb_rsp_t         res_q;

	logic [AW-1:0]     mem_addr;
	logic              mem_we;
	logic [CELL_W-1:0] mem_wdata;
	logic [CELL_W-1:0] mem_rdata;

	logic [FW-1:0]     y1, y2, f1, f2, v1, v2, vs_ext;
	logic [CW-1:0]     x1;
	logic              sh;
	logic              wr;
	logic [FW-1:0]     line;
	logic              rd_ok;
	logic [CURSOR_W+RW-1:0] quo_prod;
	logic [PRW-1:0]    base_nx;

	// Map a logical row onto the ring of physical rows
	function automatic logic [PRW-1:0] ring_row(input logic [SW-1:0] lr,
			input logic [PRW-1:0] b);
		logic [SW-1:0] s;
		s = lr + SW'(b);
		if (s >= SW'(TOTAL)) begin
			s = s - SW'(TOTAL);
		end
		return PRW'(s);
	endfunction

	// Character step: cursor move, fill count, view follow and scroll
	always_comb begin
		vs_ext = FW'(vs_q);
		y1     = row_q;
		x1     = col_q;
		f1     = filled_q;
		v1     = vs_ext;
		sh     = 1'b0;
		wr     = 1'b0;
		if (req_q.char_code == CH_FF) begin
			if (filled_q != '0 && vs_ext + FW'(VISIBLE_ROWS) < filled_q) begin
				v1 = vs_ext + 1'b1;
			end
			sh = 1'b1;
			if (row_q != '0) begin
				y1 = row_q - 1'b1;
			end
			if (filled_q < FW'(TOTAL)) begin
				f1 = filled_q + 1'b1;
			end
			if (f1 > FW'(VISIBLE_ROWS)) begin
				v1 = f1 - FW'(VISIBLE_ROWS);
			end
		end else if (req_q.char_code == CH_NL) begin
			y1 = row_q + 1'b1;
			x1 = '0;
		end else if (req_q.char_code == CH_CR) begin
			x1 = '0;
		end else begin
			wr = 1'b1;
			if (col_q == CW'(COLUMNS - 1)) begin
				x1 = '0;
				y1 = row_q + 1'b1;
			end else begin
				x1 = col_q + 1'b1;
			end
		end
		f2 = (y1 >= f1) ? y1 + 1'b1 : f1;
		v2 = (f2 > FW'(VISIBLE_ROWS)) ? f2 - FW'(VISIBLE_ROWS) : v1;
		y2 = y1;
		if (y1 >= FW'(TOTAL)) begin
			sh = 1'b1;
			y2 = FW'(TOTAL - 1);
			f2 = FW'(TOTAL);
			v2 = FW'(HISTORY_ROWS);
		end
	end

	// Cell read lookup
	always_comb begin
		line  = vs_ext + FW'(req_q.view_row);
		rd_ok = (int'(req_q.view_row) < VISIBLE_ROWS) && (int'(req_q.view_col) < COLUMNS)
			&& (line < filled_q);
	end

	// Row of the cursor value by a multiply with the column reciprocal
	assign quo_prod = (CURSOR_W+RW)'(req_q.cursor_value) * (CURSOR_W+RW)'(RECIP);

	assign base_nx = (base_q == PRW'(TOTAL - 1)) ? '0 : base_q + 1'b1;

	// Latch the transaction
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			req_q <= item;
		end
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ink_q   <= FG_RESET;
			paper_q <= BG_RESET;
			irqen_q <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_INK:   ink_q   <= cfg_data;
				CFG_PAPER: paper_q <= cfg_data[2:0];
				CFG_IRQEN: irqen_q <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// Console state, store pointer and cursor split
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q    <= '0;
			col_q    <= '0;
			vs_q     <= '0;
			filled_q <= '0;
			base_q   <= '0;
			prow_q   <= '0;
			pcol_q   <= '0;
			shift_q  <= 1'b0;
			wr_q     <= 1'b0;
			pulse_q  <= 1'b0;
			blank_q  <= 1'b0;
			dq_q     <= '0;
		end else begin
			if (cmd.exec) begin
				shift_q <= 1'b0;
				wr_q    <= 1'b0;
				pulse_q <= 1'b0;
				case (req_q.mode)
					MODE_CHAR: begin
						if (req_q.char_code != CH_NUL) begin
							row_q    <= y2;
							col_q    <= x1;
							filled_q <= f2;
							vs_q     <= VW'(v2);
							shift_q  <= sh;
							wr_q     <= wr;
							pulse_q  <= irqen_q;
							prow_q   <= ring_row(SW'(row_q), base_q);
							pcol_q   <= col_q;
							if (sh) begin
								base_q <= base_nx;
							end
						end
					end
					MODE_SET: begin
						dq_q <= CURSOR_W'(quo_prod >> RS);
					end
					MODE_VIEW_UP: begin
						if (vs_q != '0) begin
							vs_q <= vs_q - 1'b1;
						end
					end
					MODE_VIEW_DOWN: begin
						if (filled_q > FW'(VISIBLE_ROWS)
								&& vs_ext + FW'(VISIBLE_ROWS) < filled_q) begin
							vs_q <= vs_q + 1'b1;
						end
					end
					MODE_CLEAR: begin
						row_q    <= '0;
						col_q    <= '0;
						vs_q     <= '0;
						filled_q <= '0;
						prow_q   <= '0;
						pcol_q   <= '0;
					end
					MODE_READ: begin
						blank_q <= !rd_ok;
						prow_q  <= rd_ok ? ring_row(SW'(line), base_q) : '0;
						pcol_q  <= rd_ok ? CW'(req_q.view_col) : '0;
					end
					default: begin
					end
				endcase
			end
			// Point at the new last row after a scroll
			if (cmd.blank_init) begin
				prow_q <= ring_row(SW'(TOTAL - 1), base_q);
				pcol_q <= '0;
			end
			// Advance the sweep pointer
			if (cmd.sweep) begin
				if (pcol_q == CW'(COLUMNS - 1)) begin
					pcol_q <= '0;
					prow_q <= (prow_q == PRW'(TOTAL - 1)) ? '0 : prow_q + 1'b1;
				end else begin
					pcol_q <= pcol_q + 1'b1;
				end
			end
			// Clamp a position beyond the store to the last row
			if (cmd.div_apply) begin
				if (dq_q >= CURSOR_W'(TOTAL)) begin
					row_q <= FW'(TOTAL - 1);
				end else begin
					row_q <= FW'(dq_q);
				end
				col_q <= CW'(req_q.cursor_value - dq_q * CURSOR_W'(COLUMNS));
			end
		end
	end

	// Store access
	always_comb begin
		mem_addr = AW'(prow_q) * AW'(COLUMNS) + AW'(pcol_q);
		mem_we   = cmd.sweep | (cmd.write & wr_q);
		if (cmd.sweep) begin
			mem_wdata = cmd.fill_reset ? make_cell(CH_SPACE, FG_RESET, BG_RESET)
				: make_cell(CH_SPACE, ink_q, paper_q);
		end else begin
			mem_wdata = make_cell(req_q.char_code, ink_q, paper_q);
		end
	end

	tmcb_ram #(
		.WIDTH(CELL_W),
		.DEPTH(CELLS)
	) u_store (
		.clk  (clk),
		.we   (mem_we),
		.addr (mem_addr),
		.wdata(mem_wdata),
		.rdata(mem_rdata)
	);

	// Result register
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			res_q.cursor_out      <= CURSOR_W'(AW'(row_q) * AW'(COLUMNS) + AW'(col_q));
			res_q.view_start_out  <= 4'(vs_q);
			res_q.filled_rows_out <= 6'(filled_q);
			res_q.irq             <= (req_q.mode == MODE_CHAR) && pulse_q;
			res_q.more_above      <= (vs_q != '0);
			res_q.more_below      <= (vs_ext + FW'(VISIBLE_ROWS) < filled_q);
			if (req_q.mode != MODE_READ) begin
				res_q.cell_char  <= '0;
				res_q.cell_fg    <= '0;
				res_q.cell_bg    <= '0;
				res_q.cell_blank <= 1'b0;
			end else if (blank_q) begin
				res_q.cell_char  <= CH_SPACE;
				res_q.cell_fg    <= FG_RESET;
				res_q.cell_bg    <= BG_RESET;
				res_q.cell_blank <= 1'b1;
			end else begin
				res_q.cell_char  <= mem_rdata[7:0];
				res_q.cell_fg    <= mem_rdata[11:8];
				res_q.cell_bg    <= mem_rdata[14:12];
				res_q.cell_blank <= 1'b0;
			end
		end
	end

	// Result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= cmd.finish;
		end
	end

	assign result_valid   = strobe_q;
	assign result         = res_q;
	assign sts.mode       = req_q.mode;
	assign sts.shift_pend = shift_q;
	assign sts.last_col   = (pcol_q == CW'(COLUMNS - 1));
	assign sts.last_row   = (prow_q == PRW'(TOTAL - 1));

endmodule
